### hw/rtl/mlh_pkg.sv
// Shared constants for the multidimensional linear hash address block.
// No dependencies.
package mlh_pkg;
	localparam int NUM_ATTRS_DEF  = 4;
	localparam int VALUE_BITS_DEF = 31;
	localparam int MAX_LEVEL_DEF  = 15;
	localparam int PORT_ATTRS     = 4;
	localparam int LEVEL_W        = 4;
	localparam int COUNT_W        = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam logic [CFG_IDX_W-1:0] REG_ATTR_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_A0   = 3'd1;
endpackage

### hw/rtl/multidim_linear_hash_address_top.sv
// Top level of the multidimensional linear hash address block: config
// registers, divider lanes and bit interleave. Depends on mlh_pkg, mlh_div_lane.
//   channel  | handshake            | payload
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   tuple in | start/busy           | value_a0..3, level_a0..3
//   result   | done strobe          | partition_number
// One tuple enters every cycle; done follows the accepting edge through the vld_s
// shift register and the done register, in step with the one-bit-per-stage divider lanes.
// busy is never high and cfg_ready is always high. Reset loads attr_count
// with NUM_ATTRS and each range with all ones, and clears the valid bits.
module multidim_linear_hash_address_top #(
	parameter int NUM_ATTRS  = mlh_pkg::NUM_ATTRS_DEF,
	parameter int VALUE_BITS = mlh_pkg::VALUE_BITS_DEF,
	parameter int MAX_LEVEL  = mlh_pkg::MAX_LEVEL_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mlh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mlh_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [VALUE_BITS-1:0]             value_a0,
	input  logic [VALUE_BITS-1:0]             value_a1,
	input  logic [VALUE_BITS-1:0]             value_a2,
	input  logic [VALUE_BITS-1:0]             value_a3,
	input  logic [mlh_pkg::LEVEL_W-1:0]       level_a0,
	input  logic [mlh_pkg::LEVEL_W-1:0]       level_a1,
	input  logic [mlh_pkg::LEVEL_W-1:0]       level_a2,
	input  logic [mlh_pkg::LEVEL_W-1:0]       level_a3,
	output logic                              done,
	output logic [NUM_ATTRS*MAX_LEVEL-1:0]    partition_number
);
	import mlh_pkg::*;

	localparam int DW = VALUE_BITS + MAX_LEVEL;
	localparam int OB = NUM_ATTRS * MAX_LEVEL;
	localparam int PW = $clog2(OB + 1) + 1;

	logic [COUNT_W-1:0]    attr_count_q;
	logic [VALUE_BITS-1:0] range_q [0:NUM_ATTRS-1];
	logic [VALUE_BITS-1:0] value_arr [0:PORT_ATTRS-1];
	logic [LEVEL_W-1:0]    level_arr [0:PORT_ATTRS-1];
	logic [MAX_LEVEL-1:0]  quot [0:NUM_ATTRS-1];
	logic [LEVEL_W-1:0]    lvl  [0:NUM_ATTRS-1];
	logic [DW:0]           vld_s;
	logic                  accept;
	logic [COUNT_W-1:0]    n_act;
	logic [OB-1:0]         res;
	logic [OB-1:0]         partition_q;
	logic                  done_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	assign value_arr[0] = value_a0;
	assign value_arr[1] = value_a1;
	assign value_arr[2] = value_a2;
	assign value_arr[3] = value_a3;
	assign level_arr[0] = level_a0;
	assign level_arr[1] = level_a1;
	assign level_arr[2] = level_a2;
	assign level_arr[3] = level_a3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_count_q <= COUNT_W'(NUM_ATTRS);
			for (int i = 0; i < NUM_ATTRS; i++) range_q[i] <= '1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ATTR_COUNT) begin
				attr_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < NUM_ATTRS; i++) begin
				if (cfg_index == REG_RANGE_A0 + CFG_IDX_W'(i)) begin
					range_q[i] <= cfg_data[VALUE_BITS-1:0];
				end
			end
		end
	end

	for (genvar i = 0; i < NUM_ATTRS; i++) begin : g_lane
		mlh_div_lane #(.VALUE_BITS(VALUE_BITS), .MAX_LEVEL(MAX_LEVEL)) u_lane (
			.clk       (clk),
			.value     (value_arr[i]),
			.level     (level_arr[i]),
			.range_val (range_q[i]),
			.quot      (quot[i]),
			.lvl       (lvl[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DW-1:0], accept};
		end
	end

	assign n_act = (attr_count_q > COUNT_W'(NUM_ATTRS)) ? COUNT_W'(NUM_ATTRS) : attr_count_q;

	always_comb begin
		logic [PW-1:0] pos;
		res = '0;
		for (int i = 0; i < NUM_ATTRS; i++) begin
			for (int j = 0; j < MAX_LEVEL; j++) begin
				pos = PW'(n_act) * (PW'(lvl[i]) - PW'(1) - PW'(j)) + PW'(i);
				if (COUNT_W'(i) < n_act && LEVEL_W'(j) < lvl[i] && quot[i][j]) begin
					res = res | (OB'(1) << pos);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		partition_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[DW];
		end
	end

	assign done             = done_q;
	assign partition_number = partition_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DW] |=> done) else $error("result strobe lost");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s[DW])) else $error("result strobe invented");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s[0]) else $error("accepted tuple not tracked");
endmodule

### hw/rtl/mlh_div_lane.sv
// One attribute lane: restoring divider, one quotient bit per stage,
// keeping the low quotient bits. Depends on mlh_pkg.
module mlh_div_lane #(
	parameter int VALUE_BITS = 31,
	parameter int MAX_LEVEL  = 15
) (
	input  logic                          clk,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [mlh_pkg::LEVEL_W-1:0]   level,
	input  logic [VALUE_BITS-1:0]         range_val,
	output logic [MAX_LEVEL-1:0]          quot,
	output logic [mlh_pkg::LEVEL_W-1:0]   lvl
);
	import mlh_pkg::*;

	localparam int DW = VALUE_BITS + MAX_LEVEL;

	logic [VALUE_BITS-1:0] rem_s [0:DW];
	logic [DW-1:0]         dvd_s [0:DW];
	logic [MAX_LEVEL-1:0]  q_s   [0:DW];
	logic [LEVEL_W-1:0]    lvl_s [0:DW];
	logic [LEVEL_W-1:0]    lvl_sat;

	assign lvl_sat = (level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level;

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		dvd_s[0] <= DW'(value) << lvl_sat;
		q_s[0]   <= '0;
		lvl_s[0] <= lvl_sat;
	end

	for (genvar k = 0; k < DW; k++) begin : g_step
		logic [VALUE_BITS:0] trial;
		logic                ge;
		assign trial = {rem_s[k], dvd_s[k][DW-1]};
		assign ge    = trial >= {1'b0, range_val};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? VALUE_BITS'(trial - {1'b0, range_val}) : trial[VALUE_BITS-1:0];
			dvd_s[k+1] <= dvd_s[k] << 1;
			q_s[k+1]   <= MAX_LEVEL'({q_s[k], ge});
			lvl_s[k+1] <= lvl_s[k];
		end
	end

	assign quot = q_s[DW];
	assign lvl  = lvl_s[DW];
endmodule

### tb/tb.sv
// Testbench for multidim_linear_hash_address_top: drives tuples and register writes,
// predicts each partition number and checks every done beat against it.
// Depends on mlh_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import mlh_pkg::*;

	localparam int NA = 4;
	localparam int VB = 31;
	localparam int ML = 15;
	localparam int PW = NA * ML;
	localparam int LATENCY = VB + ML + 2;
	localparam int STALL_LIMIT = 4 * LATENCY + 200;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_A1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_A2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_A3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
	localparam logic [VB-1:0] VMAX = '1;

	typedef struct {
		logic [VB-1:0] val [NA];
		logic [3:0] lvl [NA];
	} tuple_t;

	typedef struct {
		tuple_t t;
		bit has_exp;
		logic [PW-1:0] exp_pn;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic start = 0;
	logic busy;
	logic [VB-1:0] value_a0 = '0, value_a1 = '0, value_a2 = '0, value_a3 = '0;
	logic [3:0] level_a0 = '0, level_a1 = '0, level_a2 = '0, level_a3 = '0;
	logic done;
	logic [PW-1:0] partition_number;

	logic [2:0] model_count;
	logic [VB-1:0] model_range [NA];
	logic [PW-1:0] pending_pn [$];
	int errors = 0;
	int stall_cycles = 0;
	int tuples_sent = 0;
	int results_seen = 0;
	bit accepted_now;

	multidim_linear_hash_address_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.value_a0(value_a0), .value_a1(value_a1), .value_a2(value_a2), .value_a3(value_a3),
		.level_a0(level_a0), .level_a1(level_a1), .level_a2(level_a2), .level_a3(level_a3),
		.done(done), .partition_number(partition_number)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic logic [PW-1:0] hash_address(tuple_t t);
		logic [PW-1:0] pn;
		logic [63:0] q;
		int n, lv, pos;
		pn = '0;
		n = (model_count > NA) ? NA : model_count;
		for (int i = 0; i < n; i++) begin
			lv = t.lvl[i];
			if (model_range[i] == 0)
				q = '1;
			else
				q = ({33'd0, t.val[i]} << lv) / {33'd0, model_range[i]};
			for (int j = 0; j < lv; j++) begin
				pos = n * (lv - 1 - j) + i;
				if (q[j] && pos < PW)
					pn[pos] = 1'b1;
			end
		end
		return pn;
	endfunction

	always @(posedge clk) begin
		logic [PW-1:0] want;
		accepted_now = 0;
		if (arst_n && done) begin
			accepted_now = 1;
			results_seen++;
			if (pending_pn.size() == 0) begin
				$error("unexpected result partition_number=%h", partition_number);
				errors++;
			end else begin
				want = pending_pn.pop_front();
				if (partition_number !== want) begin
					$error("partition_number expected %h actual %h", want, partition_number);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy)
			accepted_now = 1;
		if (arst_n && cfg_valid && cfg_ready)
			accepted_now = 1;
		stall_cycles = accepted_now ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cycles);
			$display("FAIL multidim_linear_hash_address_top");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ATTR_COUNT)
			model_count = data[2:0];
		else if (idx >= REG_RANGE_A0 && idx <= REG_RANGE_A3)
			model_range[idx - REG_RANGE_A0] = data[VB-1:0];
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (pending_pn.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// hold start high across back-to-back beats; idle only when allowed
	task automatic send_tuple(tuple_t t, bit has_exp, logic [PW-1:0] exp_pn, bit allow_idle);
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			start <= 0;
			repeat ($urandom_range(1, 3) - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		value_a0 <= t.val[0]; value_a1 <= t.val[1];
		value_a2 <= t.val[2]; value_a3 <= t.val[3];
		level_a0 <= t.lvl[0]; level_a1 <= t.lvl[1];
		level_a2 <= t.lvl[2]; level_a3 <= t.lvl[3];
		do @(posedge clk); while (busy);
		if (has_exp && exp_pn !== hash_address(t)) begin
			$error("partition_number table %h predictor %h", exp_pn, hash_address(t));
			errors++;
		end
		pending_pn.push_back(hash_address(t));
		tuples_sent++;
	endtask

	function automatic logic [VB-1:0] rand_value(logic [VB-1:0] rng);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return VMAX;
			2: return (rng == 0) ? '0 : rng - 1;
			3: return rng;
			4: return (rng == 0) ? VB'($urandom) : VB'($urandom_range(0, rng - 1));
			default: return VB'($urandom);
		endcase
	endfunction

	function automatic tuple_t rand_tuple();
		tuple_t t;
		for (int i = 0; i < NA; i++) begin
			t.val[i] = rand_value(model_range[i]);
			t.lvl[i] = 4'($urandom_range(0, 15));
		end
		return t;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_range();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd1;
			2: return {1'b0, VMAX};
			3: return $urandom_range(1, 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic tuple_t mk(logic [VB-1:0] v, logic [3:0] l);
		tuple_t t;
		for (int i = 0; i < NA; i++) begin
			t.val[i] = v;
			t.lvl[i] = l;
		end
		return t;
	endfunction

	stim_row_t directed [$];

	initial begin
		stim_row_t r;
		tuple_t t;
		model_count = 3'd4;
		for (int i = 0; i < NA; i++)
			model_range[i] = VMAX;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// reset config: four attributes, full range
		r.t = mk('0, 4'd0); r.has_exp = 1; r.exp_pn = '0; directed.push_back(r);
		r.t = mk(VMAX, 4'd15); r.has_exp = 1; r.exp_pn = '0; directed.push_back(r);
		r.t = mk('0, 4'd15); r.has_exp = 1; r.exp_pn = '0; directed.push_back(r);
		r.t = mk(VMAX, 4'd0); r.has_exp = 1; r.exp_pn = '0; directed.push_back(r);
		r.t = mk(VMAX, 4'd1); r.has_exp = 1; r.exp_pn = '0; directed.push_back(r);
		r.t = mk(31'h4000_0000, 4'd1); r.has_exp = 0; r.exp_pn = '0; directed.push_back(r);
		r.t = mk(31'h2AAA_AAAA, 4'd15); r.has_exp = 0; directed.push_back(r);
		r.t = mk(31'h5555_5555, 4'd7); r.has_exp = 0; directed.push_back(r);
		t = mk(VMAX, 4'd15); t.lvl[1] = 0; t.lvl[3] = 4'd3;
		r.t = t; r.has_exp = 0; directed.push_back(r);
		foreach (directed[k])
			send_tuple(directed[k].t, directed[k].has_exp, directed[k].exp_pn, 0);
		drain();

		// zero range, value at or above range, attribute counts of zero, seven and one
		write_reg(REG_RANGE_A0, 32'd0);
		write_reg(REG_RANGE_A1, 32'd1);
		write_reg(REG_RANGE_A2, 32'd100);
		write_reg(REG_RANGE_A3, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'h1234);
		send_tuple(mk(31'd5, 4'd15), 0, '0, 0);
		send_tuple(mk(31'd100, 4'd4), 0, '0, 0);
		send_tuple(mk(VMAX, 4'd15), 0, '0, 0);
		drain();
		write_reg(REG_ATTR_COUNT, 32'd0);
		send_tuple(mk(VMAX, 4'd15), 1, '0, 0);
		drain();
		write_reg(REG_ATTR_COUNT, 32'd7);
		send_tuple(mk(31'd77, 4'd9), 0, '0, 0);
		drain();
		write_reg(REG_ATTR_COUNT, 32'd1);
		send_tuple(mk(31'd1, 4'd15), 0, '0, 0);
		send_tuple(mk(VMAX, 4'd15), 0, '0, 0);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			write_reg(REG_ATTR_COUNT, (phase < 8) ? 32'((phase % 4) + 1) : $urandom);
			write_reg(REG_RANGE_A0, rand_range());
			write_reg(REG_RANGE_A1, rand_range());
			write_reg(REG_RANGE_A2, rand_range());
			write_reg(REG_RANGE_A3, rand_range());
			repeat (125)
				send_tuple(rand_tuple(), 0, '0, phase < 10);
			drain();
		end

		$display("covered %0d tuples and %0d results over 12 random register settings",
			tuples_sent, results_seen);
		if (errors == 0)
			$display("PASS multidim_linear_hash_address_top");
		else
			$display("FAIL multidim_linear_hash_address_top");
		$finish;
	end
endmodule
